### rtl/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants for channel running statistics
// Item and result layouts, operation and register codes, controller states,
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int CHANNELS_DEF = 8;

  // Operation codes carried by an item
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register indexes
  localparam logic CFG_MIN_SAMPLES = 1'b0;
  localparam logic CFG_ACTIVE      = 1'b1;

  localparam logic [31:0] MIN_SAMPLES_RST = 32'd100;
  localparam logic [3:0]  ACTIVE_RST      = 4'd8;

  localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
  localparam logic [30:0]        SD_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic               opcode;
    logic [2:0]         channel;
    logic signed [31:0] sample_value;
    logic [31:0]        time_ms;
  } item_t;

  typedef struct packed {
    logic [2:0]         out_channel;
    logic [31:0]        sample_count;
    logic signed [31:0] mean_value;
    logic [30:0]        std_dev;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic signed [31:0] rate_mean;
    logic [30:0]        rate_std_dev;
    logic               channel_valid;
    logic               all_valid;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_W_LOAD,
    S_W_DIVS,
    S_W_DIV,
    S_W_MULS,
    S_W_MUL,
    S_W_ACC,
    S_W_VDIVS,
    S_W_VDIV,
    S_W_SQRTS,
    S_W_SQRT,
    S_W_END,
    S_R_DIVS,
    S_R_DIV,
    S_R_END,
    S_WRITE,
    S_RESULT
  } state_t;

  // Commands from the controller; phase selects sample (0) or rate (1) Welford
  typedef struct packed {
    logic capture;
    logic load;
    logic w_load;
    logic div_mean;
    logic mul;
    logic acc;
    logic div_var;
    logic sqrt;
    logic w_end;
    logic div_rate;
    logic r_end;
    logic write;
    logic result;
    logic phase;
  } ctl_cmd_t;

  typedef struct packed {
    logic unit_busy;
    logic ch_ok;
    logic op_clear;
    logic var_go;
    logic rate_go;
    logic out_full;
  } dp_status_t;

endpackage

### rtl/channel_running_stats.sv
// ----------------------------------------------------------------------------
// channel_running_stats: per-channel Welford mean, deviation, min, max and rate
//
//   channel   direction  handshake            payload
//   item      in         item_valid/stall     item_t
//   result    out        result_valid/stall   result_t
//   cfg       in         cfg_valid/ready      cfg_index, cfg_data
//
// Items are taken one at a time: the input stays stalled until the result of
// the last item is in the result register. An add item runs through the shared
// divider and the multiplier, and through the square root unit once the channel
// holds two samples or more; a clear or an unknown channel skips them.
// Reset is synchronous and returns every channel to its empty statistics.
// A stalled result waits in its register while the next item is processed.
// ----------------------------------------------------------------------------
module channel_running_stats #(
  parameter int CHANNELS = crs_pkg::CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  crs_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output crs_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data
);
  import crs_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t st;
  logic       cfg_we;

  // Configuration is always taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  crs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  crs_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .st           (st),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### rtl/crs_ctrl.sv
// ----------------------------------------------------------------------------
// crs_ctrl: sequencing controller
// Steps one item through load, sample Welford, rate division, rate Welford,
// write back and result hand-off, driving the datapath by commands.
// ----------------------------------------------------------------------------
module crs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  crs_pkg::dp_status_t st,
  output crs_pkg::ctl_cmd_t   cmd
);
  import crs_pkg::*;

  state_t state, state_next;
  logic   phase;

  // State and Welford phase registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_LOAD) begin
        phase <= 1'b0;
      end else if (state == S_R_END) begin
        phase <= 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (item_valid) state_next = S_LOAD;
      S_LOAD: begin
        if (!st.ch_ok || st.op_clear) state_next = S_WRITE;
        else state_next = S_W_LOAD;
      end
      S_W_LOAD:  state_next = S_W_DIVS;
      S_W_DIVS:  state_next = S_W_DIV;
      S_W_DIV:   if (!st.unit_busy) state_next = S_W_MULS;
      S_W_MULS:  state_next = S_W_MUL;
      S_W_MUL:   if (!st.unit_busy) state_next = S_W_ACC;
      S_W_ACC: begin
        if (st.var_go) state_next = S_W_VDIVS;
        else state_next = S_W_END;
      end
      S_W_VDIVS: state_next = S_W_VDIV;
      S_W_VDIV:  if (!st.unit_busy) state_next = S_W_SQRTS;
      S_W_SQRTS: state_next = S_W_SQRT;
      S_W_SQRT:  if (!st.unit_busy) state_next = S_W_END;
      S_W_END: begin
        if (!phase && st.rate_go) state_next = S_R_DIVS;
        else state_next = S_WRITE;
      end
      S_R_DIVS:  state_next = S_R_DIV;
      S_R_DIV:   if (!st.unit_busy) state_next = S_R_END;
      S_R_END:   state_next = S_W_LOAD;
      S_WRITE:   state_next = S_RESULT;
      S_RESULT:  if (!st.out_full) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd        = '0;
    cmd.phase  = phase;
    item_stall = (state != S_IDLE);
    case (state)
      S_IDLE:    cmd.capture  = item_valid;
      S_LOAD:    cmd.load     = 1'b1;
      S_W_LOAD:  cmd.w_load   = 1'b1;
      S_W_DIVS:  cmd.div_mean = 1'b1;
      S_W_MULS:  cmd.mul      = 1'b1;
      S_W_ACC:   cmd.acc      = 1'b1;
      S_W_VDIVS: cmd.div_var  = 1'b1;
      S_W_SQRTS: cmd.sqrt     = 1'b1;
      S_W_END:   cmd.w_end    = 1'b1;
      S_R_DIVS:  cmd.div_rate = 1'b1;
      S_R_END:   cmd.r_end    = 1'b1;
      S_WRITE:   cmd.write    = 1'b1;
      S_RESULT:  cmd.result   = !st.out_full;
      default:   cmd.capture  = 1'b0;
    endcase
  end

endmodule

### rtl/crs_dp.sv
// ----------------------------------------------------------------------------
// crs_dp: statistics datapath
// Per-channel state, configuration registers, a Welford working set, a shared
// radix-2 divider, a shift-add multiplier, a square root unit and the
// result register.
// ----------------------------------------------------------------------------
module crs_dp #(
  parameter int CHANNELS = crs_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  input  crs_pkg::item_t      item,
  input  crs_pkg::ctl_cmd_t   cmd,
  output crs_pkg::dp_status_t st,
  output logic                result_valid,
  input  logic                result_stall,
  output crs_pkg::result_t    result
);
  import crs_pkg::*;

  // Only channels 0..7 are addressable by an item
  localparam int NCH = (CHANNELS > 8) ? 8 : CHANNELS;
  localparam int IW  = (NCH > 1) ? $clog2(NCH) : 1;

  // Configuration
  logic [31:0] min_samples;
  logic [3:0]  active_channels;

  // Per-channel stores
  logic [31:0]        cnt_st    [NCH];
  logic signed [31:0] mean_st   [NCH];
  logic [63:0]        m2_st     [NCH];
  logic [30:0]        sd_st     [NCH];
  logic signed [31:0] low_st    [NCH];
  logic signed [31:0] high_st   [NCH];
  logic signed [31:0] rmean_st  [NCH];
  logic [63:0]        rm2_st    [NCH];
  logic [30:0]        rsd_st    [NCH];
  logic               seen_st   [NCH];
  logic signed [31:0] last_s_st [NCH];
  logic [31:0]        last_t_st [NCH];
  logic [CHANNELS-1:0] vbits;

  // Captured item and working copy of the addressed channel
  item_t              it;
  logic               ch_ok;
  logic [IW-1:0]      idx;
  logic [31:0]        cnt;
  logic signed [31:0] mean, rmean, low, high, last_s;
  logic [63:0]        m2, rm2;
  logic [30:0]        sd, rsd;
  logic               seen;
  logic [31:0]        last_t;
  logic signed [31:0] rate;
  logic               rneg;

  // Welford working set
  logic signed [31:0] wx, wmean;
  logic [31:0]        wn;
  logic [63:0]        wm2;
  logic [30:0]        wsd;
  logic signed [32:0] delta;

  // Divider
  logic        dbusy;
  logic [6:0]  dcnt;
  logic [63:0] dq;
  logic [31:0] drem, dvs;
  logic [32:0] d_r2, d_sub;
  logic        d_ge;
  logic [63:0] d_dvd_in;
  logic [31:0] d_dvs_in;

  // Multiplier
  logic        mbusy;
  logic [5:0]  mcnt;
  logic [63:0] macc, mcand;
  logic [32:0] mplr;

  // Square root
  logic        sbusy;
  logic [5:0]  scnt;
  logic [63:0] sv;
  logic [33:0] srem;
  logic [31:0] sroot;
  logic [35:0] s_sh, s_trial;
  logic        s_ge;

  // Combinational helpers
  logic signed [31:0] sel_x, sel_mean;
  logic [32:0]        delta_mag, d2_mag, dv_mag, q_lo;
  logic signed [32:0] nm33, d2, dv;
  logic [42:0]        dv_k;
  logic [64:0]        m2_sum;
  logic [31:0]        dt;
  logic [30:0]        sd_new;
  logic               all_ok;
  int                 lim;

  assign idx = it.channel[IW-1:0];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples     <= MIN_SAMPLES_RST;
      active_channels <= ACTIVE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MIN_SAMPLES) min_samples <= cfg_data;
      else active_channels <= cfg_data[3:0];
    end
  end

  // Operand preparation for the Welford and rate steps
  always_comb begin
    sel_x     = cmd.phase ? rate : it.sample_value;
    sel_mean  = cmd.phase ? rmean : mean;
    delta_mag = delta[32] ? 33'(-delta) : 33'(delta);
    q_lo      = dq[32:0];
    nm33      = delta[32] ? ({wmean[31], wmean} - $signed(q_lo))
                          : ({wmean[31], wmean} + $signed(q_lo));
    d2        = {wx[31], wx} - {nm33[31], nm33[31:0]};
    d2_mag    = d2[32] ? 33'(-d2) : 33'(d2);
    dv        = {it.sample_value[31], it.sample_value} - {last_s[31], last_s};
    dv_mag    = dv[32] ? 33'(-dv) : 33'(dv);
    // times 1000 = 1024 - 16 - 8
    dv_k      = {dv_mag, 10'd0} - {6'd0, dv_mag, 4'd0} - {7'd0, dv_mag, 3'd0};
    m2_sum    = {1'b0, wm2} + {1'b0, macc};
    dt        = it.time_ms - last_t;
    sd_new    = sroot[31] ? SD_MAX : sroot[30:0];
    if (cmd.div_rate) begin
      d_dvd_in = {21'd0, dv_k};
      d_dvs_in = dt;
    end else if (cmd.div_var) begin
      d_dvd_in = wm2;
      d_dvs_in = wn - 32'd1;
    end else begin
      d_dvd_in = {31'd0, delta_mag};
      d_dvs_in = wn;
    end
  end

  // Radix-2 restoring divider, one quotient bit per cycle
  assign d_r2  = {drem, dq[63]};
  assign d_ge  = d_r2 >= {1'b0, dvs};
  assign d_sub = d_r2 - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt  <= '0;
    end else if (cmd.div_mean || cmd.div_var || cmd.div_rate) begin
      dbusy <= 1'b1;
      dcnt  <= 7'd64;
    end else if (dbusy) begin
      dcnt <= dcnt - 7'd1;
      if (dcnt == 7'd1) dbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_mean || cmd.div_var || cmd.div_rate) begin
      dq   <= d_dvd_in;
      dvs  <= d_dvs_in;
      drem <= '0;
    end else if (dbusy) begin
      drem <= d_ge ? d_sub[31:0] : d_r2[31:0];
      dq   <= {dq[62:0], d_ge};
    end
  end

  // Shift-add multiplier, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mcnt  <= '0;
    end else if (cmd.mul) begin
      mbusy <= 1'b1;
      mcnt  <= 6'd33;
    end else if (mbusy) begin
      mcnt <= mcnt - 6'd1;
      if (mcnt == 6'd1) mbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      macc  <= '0;
      mcand <= {31'd0, delta_mag};
      mplr  <= d2_mag;
    end else if (mbusy) begin
      if (mplr[0]) macc <= macc + mcand;
      mcand <= {mcand[62:0], 1'b0};
      mplr  <= {1'b0, mplr[32:1]};
    end
  end

  // Digit-by-digit integer square root, one root bit per cycle
  assign s_sh    = {srem, sv[63:62]};
  assign s_trial = {2'd0, sroot, 2'b01};
  assign s_ge    = s_sh >= s_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      sbusy <= 1'b0;
      scnt  <= '0;
    end else if (cmd.sqrt) begin
      sbusy <= 1'b1;
      scnt  <= 6'd32;
    end else if (sbusy) begin
      scnt <= scnt - 6'd1;
      if (scnt == 6'd1) sbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt) begin
      sv    <= dq;
      srem  <= '0;
      sroot <= '0;
    end else if (sbusy) begin
      srem  <= s_ge ? 34'(s_sh - s_trial) : s_sh[33:0];
      sroot <= {sroot[30:0], s_ge};
      sv    <= {sv[61:0], 2'b00};
    end
  end

  // Item capture, channel load and Welford bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it    <= item;
      ch_ok <= {29'd0, item.channel} < 32'(CHANNELS);
    end
    if (cmd.load) begin
      cnt    <= (it.opcode == OP_ADD && cnt_st[idx] != '1) ? cnt_st[idx] + 32'd1
                                                            : cnt_st[idx];
      mean   <= mean_st[idx];
      m2     <= m2_st[idx];
      sd     <= sd_st[idx];
      low    <= low_st[idx];
      high   <= high_st[idx];
      rmean  <= rmean_st[idx];
      rm2    <= rm2_st[idx];
      rsd    <= rsd_st[idx];
      seen   <= seen_st[idx];
      last_s <= last_s_st[idx];
      last_t <= last_t_st[idx];
    end
    if (cmd.w_load) begin
      wx    <= sel_x;
      wn    <= cmd.phase ? cnt - 32'd1 : cnt;
      wmean <= sel_mean;
      wm2   <= cmd.phase ? rm2 : m2;
      wsd   <= cmd.phase ? rsd : sd;
      delta <= {sel_x[31], sel_x} - {sel_mean[31], sel_mean};
    end
    // The new mean is formed from the quotient as the product starts
    if (cmd.mul) begin
      wmean <= nm33[31:0];
    end
    if (cmd.acc) begin
      wm2 <= m2_sum[64] ? '1 : m2_sum[63:0];
    end
    if (cmd.w_end) begin
      if (cmd.phase) begin
        rmean <= wmean;
        rm2   <= wm2;
        rsd   <= (wn > 32'd1) ? sd_new : wsd;
      end else begin
        mean <= wmean;
        m2   <= wm2;
        sd   <= (wn > 32'd1) ? sd_new : wsd;
      end
    end
    if (cmd.div_rate) begin
      rneg <= dv[32];
    end
    // Rate saturates to the signed 32-bit range
    if (cmd.r_end) begin
      if (rneg) rate <= (dq > 64'h8000_0000) ? Q_MIN : $signed(-dq[31:0]);
      else rate <= (dq > 64'h7FFF_FFFF) ? Q_MAX : $signed(dq[31:0]);
    end
  end

  // Store write back: clear or add
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        cnt_st[i]    <= '0;
        mean_st[i]   <= '0;
        m2_st[i]     <= '0;
        sd_st[i]     <= '0;
        low_st[i]    <= Q_MAX;
        high_st[i]   <= Q_MIN;
        rmean_st[i]  <= '0;
        rm2_st[i]    <= '0;
        rsd_st[i]    <= '0;
        seen_st[i]   <= 1'b0;
        last_s_st[i] <= '0;
        last_t_st[i] <= '0;
      end
      vbits <= '0;
    end else if (cmd.write && ch_ok) begin
      if (it.opcode == OP_CLEAR) begin
        cnt_st[idx]    <= '0;
        mean_st[idx]   <= '0;
        m2_st[idx]     <= '0;
        sd_st[idx]     <= '0;
        low_st[idx]    <= Q_MAX;
        high_st[idx]   <= Q_MIN;
        rmean_st[idx]  <= '0;
        rm2_st[idx]    <= '0;
        rsd_st[idx]    <= '0;
        seen_st[idx]   <= 1'b0;
        last_s_st[idx] <= '0;
        last_t_st[idx] <= '0;
      end else begin
        cnt_st[idx]    <= cnt;
        mean_st[idx]   <= mean;
        m2_st[idx]     <= m2;
        sd_st[idx]     <= sd;
        low_st[idx]    <= (it.sample_value < low) ? it.sample_value : low;
        high_st[idx]   <= (it.sample_value > high) ? it.sample_value : high;
        rmean_st[idx]  <= rmean;
        rm2_st[idx]    <= rm2;
        rsd_st[idx]    <= rsd;
        seen_st[idx]   <= 1'b1;
        last_s_st[idx] <= it.sample_value;
        last_t_st[idx] <= it.time_ms;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        if (i == int'(it.channel)) begin
          if (it.opcode == OP_CLEAR) vbits[i] <= 1'b0;
          else if (cnt >= min_samples) vbits[i] <= 1'b1;
        end
      end
    end
  end

  // All-valid flag over the active channels
  always_comb begin
    lim    = (int'(active_channels) > CHANNELS) ? CHANNELS : int'(active_channels);
    all_ok = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (i < lim && !vbits[i]) all_ok = 1'b0;
    end
  end

  // Result register; a transfer frees it for the next item
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.result) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      result             <= '0;
      result.out_channel <= it.channel;
      result.all_valid   <= all_ok;
      if (ch_ok) begin
        result.sample_count  <= cnt_st[idx];
        result.mean_value    <= mean_st[idx];
        result.std_dev       <= sd_st[idx];
        result.min_value     <= low_st[idx];
        result.max_value     <= high_st[idx];
        result.rate_mean     <= rmean_st[idx];
        result.rate_std_dev  <= rsd_st[idx];
        result.channel_valid <= vbits[it.channel[IW-1:0]];
      end
    end
  end

  // Status to the controller
  always_comb begin
    st.unit_busy = dbusy | mbusy | sbusy;
    st.ch_ok     = ch_ok;
    st.op_clear  = (it.opcode == OP_CLEAR);
    st.var_go    = (wn > 32'd1);
    st.rate_go   = seen && (dt != 32'd0) && (cnt != 32'd1);
    st.out_full  = result_valid;
  end

endmodule

### rtl/crs_checker.sv
// ----------------------------------------------------------------------------
// crs_checker: port-level checks for channel running statistics
// Watches the top-level ports for busy handling, result holding and
// consistency of the reported statistics.
// ----------------------------------------------------------------------------
module crs_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input crs_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input crs_pkg::result_t result,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic             cfg_index,
  input logic [31:0]      cfg_data
);
  import crs_pkg::*;

  // An accepted item keeps the input stalled while it is processed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input not stalled after a transfer");

  // A stalled result is held
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // A deviation needs at least two samples
  a_sd_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.std_dev != '0 |-> result.sample_count > 32'd1)
    else $error("deviation reported with fewer than two samples");

  // Minimum never exceeds maximum once a sample was seen
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.sample_count != '0 |-> result.min_value <= result.max_value)
    else $error("minimum above maximum");

endmodule

bind channel_running_stats crs_checker u_crs_checker (.*);

### dv/channel_running_stats_tb.sv
// ----------------------------------------------------------------------------
// channel_running_stats_tb: self-checking bench for per-channel running stats
// Drives add and clear items in random bursts, stalls the result channel on a
// pattern of its own, and compares each result against a behavioral Welford
// predictor kept inside the bench. Registers are rewritten between phases.
// ----------------------------------------------------------------------------
module channel_running_stats_tb;
  import crs_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_MIN_SAMPLES;
  logic [31:0] cfg_data = '0;

  channel_running_stats DUT (.*);

  always #5 clk = ~clk;

  // Predictor state, one entry per channel.
  logic [31:0]        ms_thresh;
  logic [3:0]         ms_active;
  logic [31:0]        st_count [8];
  longint             st_mean [8];
  logic [63:0]        st_m2 [8];
  logic [30:0]        st_sd [8];
  longint             st_low [8];
  longint             st_high [8];
  longint             st_rmean [8];
  logic [63:0]        st_rm2 [8];
  logic [30:0]        st_rsd [8];
  bit                 st_valid [8];
  bit                 st_seen [8];
  longint             st_last [8];
  logic [31:0]        st_tlast [8];

  item_t   pending_items [$];
  result_t expected_stats [$];
  int      fail_count = 0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // One Welford step on mean, sum of squared deviations and deviation.
  task automatic welford_step(input longint x, input logic [31:0] n, inout longint mean,
                              inout logic [63:0] m2, inout logic [30:0] sd);
    longint      delta;
    longint      nm;
    longint      d2;
    logic [63:0] prod;
    logic [63:0] r;
    delta = x - mean;
    nm = mean + delta / longint'({32'd0, n});
    d2 = x - nm;
    prod = (delta < 0 ? -delta : delta) * (d2 < 0 ? -d2 : d2);
    mean = nm;
    m2 = (m2 > ~64'd0 - prod) ? ~64'd0 : m2 + prod;
    if (n > 1) begin
      r = isqrt(m2 / {32'd0, n - 32'd1});
      sd = (r > 64'h7FFF_FFFF) ? SD_MAX : r[30:0];
    end
  endtask

  task automatic clear_chan(input int c);
    st_count[c] = '0; st_mean[c] = 0; st_m2[c] = '0; st_sd[c] = '0;
    st_low[c] = 64'sh7FFF_FFFF; st_high[c] = -64'sh8000_0000;
    st_rmean[c] = 0; st_rm2[c] = '0; st_rsd[c] = '0;
    st_valid[c] = 1'b0; st_seen[c] = 1'b0; st_last[c] = 0; st_tlast[c] = '0;
  endtask

  // Applies one item to the predictor and queues the resulting statistics.
  task automatic predict_stats(input item_t it);
    int          c;
    longint      x;
    logic [31:0] n;
    logic [31:0] dt;
    longint      rate;
    result_t     r;
    int          lim;
    c = it.channel;
    x = longint'(it.sample_value);
    if (it.opcode == OP_CLEAR) begin
      clear_chan(c);
    end else begin
      if (st_count[c] != 32'hFFFF_FFFF) st_count[c]++;
      n = st_count[c];
      welford_step(x, n, st_mean[c], st_m2[c], st_sd[c]);
      if (x < st_low[c]) st_low[c] = x;
      if (x > st_high[c]) st_high[c] = x;
      if (st_seen[c]) begin
        dt = it.time_ms - st_tlast[c];
        if (dt != 0 && n - 32'd1 != 0) begin
          rate = (x - st_last[c]) * 1000 / longint'({32'd0, dt});
          if (rate > 64'sh7FFF_FFFF) rate = 64'sh7FFF_FFFF;
          if (rate < -64'sh8000_0000) rate = -64'sh8000_0000;
          welford_step(rate, n - 32'd1, st_rmean[c], st_rm2[c], st_rsd[c]);
        end
      end
      st_last[c] = x;
      st_tlast[c] = it.time_ms;
      st_seen[c] = 1'b1;
      if (n >= ms_thresh) st_valid[c] = 1'b1;
    end
    r.out_channel = it.channel;
    r.sample_count = st_count[c];
    r.mean_value = st_mean[c][31:0];
    r.std_dev = st_sd[c];
    r.min_value = st_low[c][31:0];
    r.max_value = st_high[c][31:0];
    r.rate_mean = st_rmean[c][31:0];
    r.rate_std_dev = st_rsd[c];
    r.channel_valid = st_valid[c];
    lim = (ms_active > 8) ? 8 : ms_active;
    r.all_valid = 1'b1;
    for (int i = 0; i < lim; i++) if (!st_valid[i]) r.all_valid = 1'b0;
    expected_stats.push_back(r);
  endtask

  // Driver: bursts of transfers separated by random gaps.
  int  burst_left = 0;
  int  gap_left = 0;
  bit  hold_off = 1'b0;
  always @(posedge clk) begin
    if (!rst && !(item_valid && item_stall)) begin
      if (item_valid) predict_stats(item);
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        item_valid <= 1'b0;
      end else if (!hold_off && pending_items.size() > 0) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: quiet stretches mixed with heavy stalling.
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 999) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      default: result_stall <= ($urandom_range(0, 99) < 90);
    endcase
  end

  // Monitor: each result transfer is matched with the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (!rst && result_valid && !result_stall) begin
      if (expected_stats.size() == 0) begin
        $error("result with no expectation: %p", result);
        fail_count++;
      end else begin
        e = expected_stats.pop_front();
        if (result.out_channel !== e.out_channel) begin
          $error("out_channel exp %0d got %0d", e.out_channel, result.out_channel);
          fail_count++;
        end
        if (result.sample_count !== e.sample_count) begin
          $error("sample_count exp %0d got %0d", e.sample_count, result.sample_count);
          fail_count++;
        end
        if (result.mean_value !== e.mean_value) begin
          $error("mean_value exp %0d got %0d", e.mean_value, result.mean_value);
          fail_count++;
        end
        if (result.std_dev !== e.std_dev) begin
          $error("std_dev exp %0d got %0d", e.std_dev, result.std_dev);
          fail_count++;
        end
        if (result.min_value !== e.min_value) begin
          $error("min_value exp %0d got %0d", e.min_value, result.min_value);
          fail_count++;
        end
        if (result.max_value !== e.max_value) begin
          $error("max_value exp %0d got %0d", e.max_value, result.max_value);
          fail_count++;
        end
        if (result.rate_mean !== e.rate_mean) begin
          $error("rate_mean exp %0d got %0d", e.rate_mean, result.rate_mean);
          fail_count++;
        end
        if (result.rate_std_dev !== e.rate_std_dev) begin
          $error("rate_std_dev exp %0d got %0d", e.rate_std_dev, result.rate_std_dev);
          fail_count++;
        end
        if (result.channel_valid !== e.channel_valid) begin
          $error("channel_valid exp %0d got %0d", e.channel_valid, result.channel_valid);
          fail_count++;
        end
        if (result.all_valid !== e.all_valid) begin
          $error("all_valid exp %0d got %0d", e.all_valid, result.all_valid);
          fail_count++;
        end
      end
    end
  end

  function automatic item_t make_add(int c, logic [31:0] v, logic [31:0] t);
    item_t it;
    it.opcode = OP_ADD;
    it.channel = 3'(c);
    it.sample_value = v;
    it.time_ms = t;
    return it;
  endfunction

  function automatic item_t make_clear(int c);
    item_t it;
    it = make_add(c, $urandom, $urandom);
    it.opcode = OP_CLEAR;
    return it;
  endfunction

  // Waits until every queued item went out and every result came back.
  task automatic drain();
    while (pending_items.size() > 0 || item_valid || expected_stats.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // One register write; the trailing edge keeps back-to-back writes apart.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_MIN_SAMPLES) ms_thresh = val;
    else ms_active = val[3:0];
    @(posedge clk);
  endtask

  // Well-formed runs of samples on one channel with varied steps.
  task automatic random_phase(int items);
    int          c;
    int          len;
    logic [31:0] t;
    logic [31:0] v;
    int          sent;
    sent = 0;
    while (sent < items) begin
      c = $urandom_range(0, 7);
      len = $urandom_range(1, 20);
      t = $urandom;
      v = $urandom;
      if ($urandom_range(0, 9) == 0) begin
        pending_items.push_back(make_clear(c));
        sent++;
      end
      for (int k = 0; k < len && sent < items; k++) begin
        case ($urandom_range(0, 4))
          0: v = $urandom;
          1: v = v + $urandom_range(0, 65535) - 32768;
          2: v = ($urandom_range(0, 1)) ? Q_MAX : Q_MIN;
          default: v = v + $urandom_range(0, 2000) - 1000;
        endcase
        case ($urandom_range(0, 5))
          0: t = t;
          1: t = $urandom;
          2: t = t + 1;
          default: t = t + $urandom_range(1, 5000);
        endcase
        pending_items.push_back(make_add(c, v, t));
        sent++;
      end
    end
  endtask

  initial begin
    ms_thresh = MIN_SAMPLES_RST;
    ms_active = ACTIVE_RST;
    for (int c = 0; c < 8; c++) clear_chan(c);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, zero time step, time wrap, clears, saturating rate.
    write_reg(CFG_MIN_SAMPLES, 32'd0);
    write_reg(CFG_ACTIVE, 32'd1);
    pending_items.push_back(make_add(0, Q_MAX, 32'hFFFF_FFFF));
    pending_items.push_back(make_add(0, Q_MIN, 32'd0));
    pending_items.push_back(make_add(0, Q_MAX, 32'd1));
    pending_items.push_back(make_add(0, 32'd0, 32'd1));
    pending_items.push_back(make_add(0, 32'hFFFF_FFFF, 32'd5));
    pending_items.push_back(make_clear(0));
    pending_items.push_back(make_add(0, 32'h0001_0000, 32'd100));
    pending_items.push_back(make_clear(7));
    pending_items.push_back(make_add(7, 32'hAAAA_AAAA, 32'h5555_5555));
    pending_items.push_back(make_add(7, 32'h5555_5555, 32'hAAAA_AAAA));
    pending_items.push_back(make_add(7, Q_MIN, 32'hAAAA_AAAB));
    drain();
    // The sender holds off while the next items are queued, then resumes.
    hold_off = 1'b1;
    random_phase(20);
    repeat (50) @(posedge clk);
    hold_off = 1'b0;
    drain();

    write_reg(CFG_MIN_SAMPLES, 32'd3);
    write_reg(CFG_ACTIVE, 32'd0);
    random_phase(130);
    drain();
    write_reg(CFG_MIN_SAMPLES, 32'hFFFF_FFFF);
    write_reg(CFG_ACTIVE, 32'd15);
    random_phase(100);
    drain();
    write_reg(CFG_MIN_SAMPLES, 32'd10);
    write_reg(CFG_ACTIVE, 32'd8);
    random_phase(150);
    drain();

    if (fail_count == 0) begin
      $display("channel_running_stats regression: pass");
    end else begin
      $display("channel_running_stats regression: fail");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin
    #20_000_000;
    $display("channel_running_stats regression: fail");
    $finish;
  end
endmodule
